// ----- hdl/pitp_pkg.sv -----
`default_nettype none

package pitp_pkg;

   // Signed range of the parsed value, in bits.
   localparam int VALUE_BITS = 32;
   // Width used to form the two's complement result before it is cut to 32 bits.
   localparam int VALUE_W    = (VALUE_BITS > 32) ? VALUE_BITS : 32;
   // Magnitude times the largest base (16), plus a digit, never needs more.
   localparam int PROD_BITS  = VALUE_BITS + 5;

   // Parse phases
   localparam logic [1:0] PH_LEAD   = 2'd0;
   localparam logic [1:0] PH_ZERO   = 2'd1;
   localparam logic [1:0] PH_PREFIX = 2'd2;
   localparam logic [1:0] PH_DIGITS = 2'd3;

   // Radix codes
   localparam logic [1:0] RX_BIN = 2'd0;
   localparam logic [1:0] RX_OCT = 2'd1;
   localparam logic [1:0] RX_DEC = 2'd2;
   localparam logic [1:0] RX_HEX = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   // Character codes
   localparam logic [7:0] CH_TAB      = 8'd9;
   localparam logic [7:0] CH_NEWLINE  = 8'd10;
   localparam logic [7:0] CH_CR       = 8'd13;
   localparam logic [7:0] CH_SPACE    = 8'd32;
   localparam logic [7:0] CH_MINUS    = 8'd45;
   localparam logic [7:0] CH_ZERO     = 8'd48;
   localparam logic [7:0] CH_NINE     = 8'd57;
   localparam logic [7:0] CH_UPPER_A  = 8'd65;
   localparam logic [7:0] CH_UPPER_F  = 8'd70;
   localparam logic [7:0] CH_UPPER_X  = 8'd88;
   localparam logic [7:0] CH_LOWER_A  = 8'd97;
   localparam logic [7:0] CH_LOWER_B  = 8'd98;
   localparam logic [7:0] CH_LOWER_F  = 8'd102;
   localparam logic [7:0] CH_LOWER_X  = 8'd120;
   localparam logic [7:0] LOWER_BIAS  = 8'd87;   // 'a' - 10
   localparam logic [7:0] UPPER_BIAS  = 8'd55;   // 'A' - 10

   localparam logic [4:0] DIGIT_NONE  = 5'd16;
   localparam logic [4:0] DIGIT_NINE  = 5'd9;

   typedef logic [VALUE_BITS-1:0] mag_type;

   // Magnitude of the most negative value; also the clamp point.
   localparam mag_type NEG_LIMIT = mag_type'(1'b1) << (VALUE_BITS - 1);

   typedef struct packed {
      logic [1:0] phase;
      logic       neg;
      logic [1:0] radix;
      mag_type    acc;
      logic       err;
      logic       ovf;
   } parse_state_type;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
      logic [1:0]  radix;
   } result_type;

   localparam parse_state_type STATE_RESET = '{
      phase: PH_LEAD, neg: 1'b0, radix: RX_DEC, acc: '0, err: 1'b0, ovf: 1'b0
   };

   function automatic logic is_space(input logic [7:0] ch);
      return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   endfunction

   // 0..15, or DIGIT_NONE for anything that is not a hex digit
   function automatic logic [4:0] digit_of(input logic [7:0] ch);
      logic [7:0] d;
      d = {3'b000, DIGIT_NONE};
      if ((ch >= CH_ZERO) && (ch <= CH_NINE))
         d = ch - CH_ZERO;
      else if ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_F))
         d = ch - LOWER_BIAS;
      else if ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_F))
         d = ch - UPPER_BIAS;
      return d[4:0];
   endfunction

   function automatic logic [4:0] radix_base(input logic [1:0] rx);
      logic [4:0] b;
      unique case (rx)
         RX_BIN:  b = 5'd2;
         RX_OCT:  b = 5'd8;
         RX_DEC:  b = 5'd10;
         default: b = 5'd16;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/pitp_step.sv -----
`default_nettype none

// Next-state and result logic for one character.
module pitp_step (
   input  var pitp_pkg::parse_state_type cur,
   input  var logic [7:0]                ch,
   input  var logic                      eoi,
   output var pitp_pkg::parse_state_type nxt,
   output var logic                      emit,
   output var pitp_pkg::result_type      res
);
   import pitp_pkg::*;

   logic                 space;
   logic [4:0]           digit;
   logic [PROD_BITS-1:0] acc_ext;
   logic [PROD_BITS-1:0] scaled;
   logic [PROD_BITS-1:0] sum;
   logic                 add_over;
   mag_type              add_acc;
   logic                 add_ovf;
   logic                 pos_clip;
   mag_type              mag;
   logic [VALUE_W-1:0]   mag_wide;
   logic [VALUE_W-1:0]   neg_wide;

   assign space = is_space(ch);
   assign digit = digit_of(ch);

   // acc * base + digit, the base multiply done with shifts
   always_comb begin
      acc_ext = PROD_BITS'(cur.acc);
      unique case (cur.radix)
         RX_BIN:  scaled = acc_ext << 1;
         RX_OCT:  scaled = acc_ext << 3;
         RX_DEC:  scaled = (acc_ext << 3) + (acc_ext << 1);
         default: scaled = acc_ext << 4;
      endcase
      sum      = scaled + PROD_BITS'(digit);
      add_over = sum > PROD_BITS'(NEG_LIMIT);
      if (cur.ovf) begin
         add_acc = cur.acc;
         add_ovf = 1'b1;
      end else if (add_over) begin
         add_acc = NEG_LIMIT;
         add_ovf = 1'b1;
      end else begin
         add_acc = sum[VALUE_BITS-1:0];
         add_ovf = 1'b0;
      end
   end

   // terminator result
   always_comb begin
      pos_clip = !cur.neg && (cur.acc > (NEG_LIMIT - mag_type'(1'b1)));
      mag      = pos_clip ? (NEG_LIMIT - mag_type'(1'b1)) : cur.acc;
      mag_wide = VALUE_W'(mag);
      neg_wide = VALUE_W'(0) - mag_wide;
   end

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      res  = '{value: '0, status: ST_OK, radix: cur.radix};
      if (eoi || (space && !((cur.phase == PH_LEAD) && !cur.err && (ch != CH_NEWLINE)))) begin
         emit = 1'b1;
         nxt  = STATE_RESET;
         priority if (cur.err) begin
            res.status = ST_INVALID;
         end else if (cur.phase == PH_LEAD) begin
            if (cur.neg) begin
               res.status = ST_INVALID;
            end else begin
               res.status = ST_EMPTY;
               res.radix  = RX_DEC;
            end
         end else if (cur.phase == PH_PREFIX) begin
            res.status = ST_INVALID;
         end else begin
            res.status = (cur.ovf || pos_clip) ? ST_OVERFLOW : ST_OK;
            res.value  = cur.neg ? neg_wide[31:0] : mag_wide[31:0];
         end
      end else if (!space && !cur.err) begin
         unique case (cur.phase)
            PH_LEAD: begin
               if ((ch == CH_MINUS) && !cur.neg) begin
                  nxt.neg = 1'b1;
               end else if (digit == 5'd0) begin
                  nxt.radix = RX_OCT;
                  nxt.phase = PH_ZERO;
               end else if (digit <= DIGIT_NINE) begin
                  nxt.radix = RX_DEC;
                  nxt.phase = PH_DIGITS;
                  nxt.acc   = add_acc;
                  nxt.ovf   = add_ovf;
               end else begin
                  nxt.err = 1'b1;
               end
            end
            PH_ZERO: begin
               if (ch == CH_LOWER_B) begin
                  nxt.radix = RX_BIN;
                  nxt.phase = PH_PREFIX;
               end else if ((ch == CH_LOWER_X) || (ch == CH_UPPER_X)) begin
                  nxt.radix = RX_HEX;
                  nxt.phase = PH_PREFIX;
               end else if (digit < radix_base(RX_OCT)) begin
                  nxt.phase = PH_DIGITS;
                  nxt.acc   = add_acc;
                  nxt.ovf   = add_ovf;
               end else begin
                  nxt.err = 1'b1;
               end
            end
            default: begin
               if (digit < radix_base(cur.radix)) begin
                  nxt.phase = PH_DIGITS;
                  nxt.acc   = add_acc;
                  nxt.ovf   = add_ovf;
               end else begin
                  nxt.err = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- hdl/prefixed_integer_text_parser.sv -----
// Prefixed integer text parser.
// Input stream (req_): one ASCII character per word in req_tdata; a word with
// req_tlast high marks end of text and its character is ignored. Numbers may
// be preceded by whitespace and one minus sign; prefix 0b is binary, 0x/0X
// hex, a leading 0 octal, else decimal. Whitespace or end of text ends a
// number and produces one result word.
// Result stream (rsp_): rsp_tdata carries the signed value (saturated on
// overflow, 0 on error or empty), rsp_tuser the status and the radix used.
// Throughput: one character per cycle while no result waits on a stalled
// receiver, set by the combinational state update (shift-and-add of the
// base plus a compare) between the input register and the result register.
// The terminating character is registered in the input register, and the
// result word that it causes goes into the result register, which drives
// rsp_tvalid.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the leading-whitespace phase, decimal radix, zero magnitude.
// If the receiver stalls, the result word is held; characters that cause no
// result keep flowing, and input stalls only once a second result is due.
`default_nettype none

module prefixed_integer_text_parser (
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_tvalid,
   output var logic        req_tready,
   input  var logic [7:0]  req_tdata,   // [7:0] char_code
   input  var logic        req_tlast,   // end_of_input
   output var logic        rsp_tvalid,
   input  var logic        rsp_tready,
   output var logic [31:0] rsp_tdata,   // [31:0] value
   output var logic [3:0]  rsp_tuser    // [1:0] status, [3:2] radix_used
);
   import pitp_pkg::*;

   // input register
   logic            in_vld_ff, in_vld_in;
   logic [7:0]      ch_ff, ch_in;
   logic            eoi_ff, eoi_in;

   // parser state
   parse_state_type state_ff, state_in;

   // result register
   logic            rsp_vld_ff, rsp_vld_in;
   result_type      res_ff, res_in;

   parse_state_type step_nxt;
   logic            step_emit;
   result_type      step_res;
   logic            stage_go;

   pitp_step u_step (
      .cur  (state_ff),
      .ch   (ch_ff),
      .eoi  (eoi_ff),
      .nxt  (step_nxt),
      .emit (step_emit),
      .res  (step_res)
   );

   // A character advances unless it produces a result and the result
   // register is still occupied.
   assign stage_go   = in_vld_ff && (!step_emit || !rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || stage_go;

   always_comb begin
      in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !stage_go);
      ch_in      = (req_tvalid && req_tready) ? req_tdata : ch_ff;
      eoi_in     = (req_tvalid && req_tready) ? req_tlast : eoi_ff;
      state_in   = stage_go ? step_nxt : state_ff;
      rsp_vld_in = (stage_go && step_emit) || (rsp_vld_ff && !rsp_tready);
      res_in     = (stage_go && step_emit) ? step_res : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         state_ff   <= STATE_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff  <= ch_in;
      eoi_ff <= eoi_in;
      res_ff <= res_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = res_ff.value;
   assign rsp_tuser  = {res_ff.radix, res_ff.status};

endmodule

`default_nettype wire

// ----- verif/prefixed_integer_text_parser_tb.sv -----
`default_nettype none

module prefixed_integer_text_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pitp_pkg::*;

   // Blank characters that the package does not name
   localparam logic [7:0] CH_VTAB     = 8'd11;
   localparam logic [7:0] CH_FORMFEED = 8'd12;
   localparam int         NOT_A_DIGIT = 16;
   localparam int         PHASE_WORDS = 200;   // random words per idling phase
   localparam int         MAX_PRINTED = 30;

   typedef struct packed {
      logic       last;
      logic [7:0] code;
   } char_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] char_code
   logic        req_tlast = 1'b0;   // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] value
   logic [3:0]  rsp_tuser;          // [1:0] status, [3:2] radix_used

   prefixed_integer_text_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Words waiting to go out, and parsed numbers waiting to come back
   char_word_type pending_chars[$];
   result_type    expected_numbers[$];

   int  sender_idle_pct    = 0;
   int  receiver_stall_pct = 0;
   int  words_queued       = 0;
   int  words_accepted     = 0;
   int  error_count        = 0;
   bit  req_taken          = 1'b0;   // word accepted at the last rising edge

   // ------------------------------------------------------------------
   // Number parser predictor. Magnitudes are kept 64 bits wide so the
   // clamp point and the multiply-add never wrap.
   // ------------------------------------------------------------------
   logic [1:0]  num_phase     = PH_LEAD;
   logic        num_negative  = 1'b0;
   logic [1:0]  num_radix     = RX_DEC;
   logic [63:0] num_magnitude = '0;
   logic        num_invalid   = 1'b0;
   logic        num_clamped   = 1'b0;

   function automatic logic [63:0] clamp_point();
      return 64'd1 << (VALUE_BITS - 1);
   endfunction

   function automatic bit is_blank(input logic [7:0] ch);
      return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   endfunction

   function automatic int digit_value(input logic [7:0] ch);
      if (ch >= CH_ZERO && ch <= CH_NINE) return ch - CH_ZERO;
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) return ch - CH_LOWER_A + 10;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) return ch - CH_UPPER_A + 10;
      return NOT_A_DIGIT;
   endfunction

   function automatic int base_of(input logic [1:0] rx);
      case (rx)
         RX_BIN:  return 2;
         RX_OCT:  return 8;
         RX_DEC:  return 10;
         default: return 16;
      endcase
   endfunction

   function automatic void rearm_number();
      num_phase     = PH_LEAD;
      num_negative  = 1'b0;
      num_radix     = RX_DEC;
      num_magnitude = '0;
      num_invalid   = 1'b0;
      num_clamped   = 1'b0;
   endfunction

   // Once clamped, later digits are still checked but no longer added
   function automatic void accumulate_digit(input int d);
      logic [63:0] lim;
      logic [63:0] dd;
      logic [63:0] b;
      lim = clamp_point();
      dd  = 64'(d);
      b   = 64'(base_of(num_radix));
      if (num_clamped) return;
      if (num_magnitude > (lim - dd) / b) begin
         num_clamped   = 1'b1;
         num_magnitude = lim;
      end else begin
         num_magnitude = num_magnitude * b + dd;
      end
   endfunction

   function automatic result_type finish_number();
      result_type  res;
      logic [63:0] lim;
      logic [63:0] mag;
      logic [63:0] v;
      lim = clamp_point();
      v   = '0;
      res = '{value: '0, status: ST_OK, radix: num_radix};
      if (num_invalid) begin
         res.status = ST_INVALID;
      end else if (num_phase == PH_LEAD) begin
         // lone minus is invalid, otherwise nothing was there at all
         if (num_negative) begin
            res.status = ST_INVALID;
         end else begin
            res.status = ST_EMPTY;
            res.radix  = RX_DEC;
         end
      end else if (num_phase == PH_PREFIX) begin
         res.status = ST_INVALID;
      end else begin
         mag = num_magnitude;
         if (!num_negative && mag > lim - 64'd1) begin
            mag         = lim - 64'd1;
            num_clamped = 1'b1;
         end
         if (num_clamped) res.status = ST_OVERFLOW;
         v = num_negative ? (64'd0 - mag) : mag;
      end
      res.value = v[31:0];
      rearm_number();
      return res;
   endfunction

   // One accepted word; returns 1 when it ends a number
   function automatic bit parse_char(input logic [7:0] ch, input logic last,
                                     output result_type res);
      int d;
      res = '0;
      if (last) begin
         res = finish_number();
         return 1'b1;
      end
      if (is_blank(ch)) begin
         if (num_phase == PH_LEAD && !num_invalid && ch != CH_NEWLINE) return 1'b0;
         res = finish_number();
         return 1'b1;
      end
      if (num_invalid) return 1'b0;
      d = digit_value(ch);
      case (num_phase)
         PH_LEAD: begin
            if (ch == CH_MINUS && !num_negative) begin
               num_negative = 1'b1;
            end else if (d == 0) begin
               num_radix = RX_OCT;
               num_phase = PH_ZERO;
            end else if (d <= 9) begin
               num_radix = RX_DEC;
               num_phase = PH_DIGITS;
               accumulate_digit(d);
            end else begin
               num_invalid = 1'b1;
            end
         end
         PH_ZERO: begin
            if (ch == CH_LOWER_B) begin
               num_radix = RX_BIN;
               num_phase = PH_PREFIX;
            end else if (ch == CH_LOWER_X || ch == CH_UPPER_X) begin
               num_radix = RX_HEX;
               num_phase = PH_PREFIX;
            end else if (d < 8) begin
               num_phase = PH_DIGITS;
               accumulate_digit(d);
            end else begin
               num_invalid = 1'b1;
            end
         end
         default: begin
            if (d < base_of(num_radix)) begin
               num_phase = PH_DIGITS;
               accumulate_digit(d);
            end else begin
               num_invalid = 1'b1;
            end
         end
      endcase
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Text generation
   // ------------------------------------------------------------------
   task automatic push_word(input logic [7:0] ch, input logic last);
      pending_chars.push_back('{last: last, code: ch});
      words_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_blank(input bit allow_newline);
      case ($urandom_range(0, allow_newline ? 5 : 4))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_VTAB;
         3:       return CH_FORMFEED;
         4:       return CH_CR;
         default: return CH_NEWLINE;
      endcase
   endfunction

   // Ends a number with a blank or with end of text (random char byte)
   task automatic push_terminator();
      if ($urandom_range(0, 5) == 0) push_word(8'($urandom_range(0, 255)), 1'b1);
      else push_word(pick_blank(1'b1), 1'b0);
   endtask

   // A well-formed number in a random radix; now and then a stray byte,
   // missing digits or extra zeros break or stretch it
   task automatic push_number();
      logic [63:0] mag;
      logic [63:0] lim;
      logic [1:0]  rx;
      bit          neg;
      bit          broken;
      int          b;
      int          spot;
      int          digs[$];
      lim    = clamp_point();
      rx     = 2'($urandom_range(0, 3));
      neg    = $urandom_range(0, 99) < 35;
      broken = $urandom_range(0, 9) == 0;
      case ($urandom_range(0, 9))
         0, 1:    mag = 64'($urandom_range(0, 20));
         2:       mag = lim - 64'd1;
         3:       mag = lim;
         4:       mag = lim + 64'd1;
         5:       mag = {$urandom, $urandom};
         default: mag = 64'($urandom);
      endcase
      b = base_of(rx);
      do begin
         digs.push_front(int'(mag % 64'(b)));
         mag = mag / 64'(b);
      end while (mag != 0);
      if ($urandom_range(0, 29) == 0) digs.delete();
      spot = $urandom_range(0, digs.size());

      repeat ($urandom_range(0, 2)) push_word(pick_blank(1'b0), 1'b0);
      if (neg) begin
         push_word(CH_MINUS, 1'b0);
         if ($urandom_range(0, 7) == 0) push_word(pick_blank(1'b0), 1'b0);
      end
      case (rx)
         RX_BIN: push_text("0b");
         RX_HEX: push_word(CH_ZERO, 1'b0);
         RX_OCT: push_word(CH_ZERO, 1'b0);
         default: ;
      endcase
      if (rx == RX_HEX)
         push_word($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X, 1'b0);
      if (rx != RX_DEC && $urandom_range(0, 3) == 0) push_word(CH_ZERO, 1'b0);
      for (int i = 0; i <= digs.size(); i++) begin
         if (broken && i == spot) push_word(8'($urandom_range(0, 255)), 1'b0);
         if (i < digs.size()) begin
            if (digs[i] < 10)
               push_word(CH_ZERO + 8'(digs[i]), 1'b0);
            else if ($urandom_range(0, 1))
               push_word(CH_LOWER_A + 8'(digs[i] - 10), 1'b0);
            else
               push_word(CH_UPPER_A + 8'(digs[i] - 10), 1'b0);
         end
      end
      push_terminator();
   endtask

   // Arbitrary bytes, end of text scattered in
   task automatic push_noise();
      repeat ($urandom_range(1, 6))
         push_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      push_terminator();
   endtask

   task automatic push_random_text(input int n_words);
      int goal;
      goal = words_queued + n_words;
      while (words_queued < goal) begin
         if ($urandom_range(0, 99) < 85) push_number();
         else push_noise();
      end
   endtask

   // Hold the sender back until every word is in and every number is out
   task automatic drain();
      while (words_accepted != words_queued || expected_numbers.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_PRINTED)
         $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Driver: new words and ready change at the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin : drive_chars
      char_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            w = pending_chars.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= w.code;
            req_tlast  <= w.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // ------------------------------------------------------------------
   // Monitor: both handshakes sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : observe
      result_type got;
      result_type want;
      result_type predicted;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{value: rsp_tdata, status: rsp_tuser[1:0], radix: rsp_tuser[3:2]};
            if (expected_numbers.size() == 0) begin
               report_mismatch("result word with none expected", got.value, '0);
            end else begin
               want = expected_numbers.pop_front();
               if (got.value !== want.value)
                  report_mismatch("value", got.value, want.value);
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.radix !== want.radix)
                  report_mismatch("radix_used", 32'(got.radix), 32'(want.radix));
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            words_accepted++;
            if (parse_char(req_tdata, req_tlast, predicted))
               expected_numbers.push_back(predicted);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus: directed text, then random text in four idling phases
   // ------------------------------------------------------------------
   initial begin
      rearm_number();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty line, empty end of text with all char bits set, lone zero
      push_word(CH_NEWLINE, 1'b0);
      push_word(8'hFF, 1'b1);
      push_text("0 ");
      // blank skipped after a minus, then a second minus is invalid
      push_text("-");
      push_word(CH_TAB, 1'b0);
      push_text("-");
      push_word(CH_NEWLINE, 1'b0);
      // binary prefix with no digits
      push_text("0b");
      push_word(CH_CR, 1'b0);
      // hex with mixed letter case
      push_text("0X1aF");
      push_word(CH_VTAB, 1'b0);
      // bad decimal digit, bad octal digit
      push_text("9z");
      push_word(CH_FORMFEED, 1'b0);
      push_text("08 ");
      // lone minus at end of text
      push_text("-");
      push_word(8'h00, 1'b1);
      drain();

      // no idling
      push_random_text(PHASE_WORDS);
      drain();

      // sender gaps only
      sender_idle_pct    = 55;
      receiver_stall_pct = 0;
      push_random_text(PHASE_WORDS);
      drain();

      // receiver stalls only
      sender_idle_pct    = 0;
      receiver_stall_pct = 55;
      push_random_text(PHASE_WORDS);
      drain();

      // both sides
      sender_idle_pct    = 25;
      receiver_stall_pct = 25;
      push_random_text(PHASE_WORDS);
      drain();

      // a stray late word would show up here
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_numbers.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run
   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
